@@ hdl/its2e_pkg.sv @@
// Shared types, constants and tables for the timestamp to epoch converter.
package its2e_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 5;
  localparam int unsigned YearW    = 14;
  localparam int unsigned FieldW   = 7;
  localparam int unsigned EpochW   = 39;
  localparam int unsigned OutDataW = 40;

  localparam logic [PosW-1:0] PosMax  = 5'd31;
  localparam logic [PosW-1:0] TsLen   = 5'd20;
  localparam logic [PosW-1:0] PosLast = 5'd19;

  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChT     = 8'h54;
  localparam logic [CharW-1:0] ChZ     = 8'h5A;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // Fixed-point reciprocals for the divisions by 400 and by 100.
  localparam logic [12:0] Recip400   = 13'd5243;
  localparam int unsigned Recip400Sh = 21;
  localparam logic [14:0] Recip100   = 15'd41;

  localparam logic signed [15:0] YearsPerEra  = 16'sd400;
  localparam logic [17:0]        DaysPerYear  = 18'd365;
  localparam logic signed [23:0] DaysPerEra   = 24'sd146097;
  localparam logic signed [23:0] EpochDayOfs  = 24'sd719468;
  localparam logic signed [38:0] SecsPerDay   = 39'sd86400;
  localparam logic [16:0]        SecsPerHour  = 17'd3600;
  localparam logic [16:0]        SecsPerMin   = 17'd60;

  localparam int unsigned NumStages = 5;
  localparam int unsigned StgEra  = 0;
  localparam int unsigned StgYoe  = 1;
  localparam int unsigned StgDoe  = 2;
  localparam int unsigned StgDays = 3;
  localparam int unsigned StgSecs = 4;

  typedef struct packed {
    logic                 take;
    logic                 finish;
    logic [NumStages-1:0] stage_en;
    logic                 load_out;
  } cmd_t;

  // Day of the March-based year on which each month starts.
  function automatic logic [8:0] month_offset(input logic [FieldW-1:0] month);
    logic [8:0] ofs;
    case (month)
      7'd3:    ofs = 9'd0;
      7'd4:    ofs = 9'd31;
      7'd5:    ofs = 9'd61;
      7'd6:    ofs = 9'd92;
      7'd7:    ofs = 9'd122;
      7'd8:    ofs = 9'd153;
      7'd9:    ofs = 9'd184;
      7'd10:   ofs = 9'd214;
      7'd11:   ofs = 9'd245;
      7'd12:   ofs = 9'd275;
      7'd1:    ofs = 9'd306;
      7'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

@@ hdl/its2e_dp.sv @@
// Datapath: character parser, field registers and staged epoch arithmetic.
module its2e_dp import its2e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [CharW-1:0]    ch_i,
  output logic                valid_res_o,
  output logic [EpochW-1:0]   epoch_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic              err_q, err_d, err_upd;
  logic              ok_q, ok_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [FieldW-1:0] month_q, month_d, day_q, day_d;
  logic [FieldW-1:0] hour_q, hour_d, minute_q, minute_d, second_q, second_d;

  logic              is_digit, has_sep;
  logic [CharW-1:0]  sep;
  logic [3:0]        dig;
  logic [FieldW-1:0] dig7;

  always_comb begin
    is_digit = (ch_i >= ChZero) && (ch_i <= ChNine);
    dig      = ch_i[3:0];
    dig7     = {3'b000, dig};
    has_sep  = 1'b1;
    case (pos_q)
      5'd4, 5'd7:   sep = ChDash;
      5'd10:        sep = ChT;
      5'd13, 5'd16: sep = ChColon;
      5'd19:        sep = ChZ;
      default: begin
        sep     = ChZero;
        has_sep = 1'b0;
      end
    endcase

    err_upd  = err_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (cmd_i.take && (pos_q < TsLen)) begin
      if (has_sep) begin
        if (ch_i != sep) begin
          err_upd = 1'b1;
        end
      end else if (!is_digit) begin
        err_upd = 1'b1;
      end else if (pos_q <= 5'd3) begin
        year_d = (pos_q == 5'd0) ? {10'b0, dig} : year_q * 14'd10 + {10'b0, dig};
      end else if (pos_q <= 5'd6) begin
        month_d = (pos_q == 5'd5) ? dig7 : month_q * 7'd10 + dig7;
      end else if (pos_q <= 5'd9) begin
        day_d = (pos_q == 5'd8) ? dig7 : day_q * 7'd10 + dig7;
      end else if (pos_q <= 5'd12) begin
        hour_d = (pos_q == 5'd11) ? dig7 : hour_q * 7'd10 + dig7;
      end else if (pos_q <= 5'd15) begin
        minute_d = (pos_q == 5'd14) ? dig7 : minute_q * 7'd10 + dig7;
      end else begin
        second_d = (pos_q == 5'd17) ? dig7 : second_q * 7'd10 + dig7;
      end
    end

    ok_d = !err_upd && (pos_q == PosLast)
        && (month_q >= 7'd1) && (month_q <= 7'd12)
        && (day_q >= 7'd1) && (day_q <= 7'd31)
        && (hour_q <= 7'd23) && (minute_q <= 7'd59) && (second_q <= 7'd59);

    pos_d = pos_q;
    err_d = err_upd;
    if (cmd_i.finish) begin
      pos_d = '0;
      err_d = 1'b0;
    end else if (cmd_i.take && (pos_q < PosMax)) begin
      pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      err_q    <= 1'b0;
      ok_q     <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else begin
      pos_q    <= pos_d;
      err_q    <= err_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      if (cmd_i.finish) begin
        ok_q <= ok_d;
      end
    end
  end

  // Epoch arithmetic, one registered step per stage enable.
  logic signed [14:0] y_q, y_adj;
  logic signed [5:0]  era_q, era_d;
  logic [26:0]        era_prod;
  logic [8:0]         doy_q, doy_d;
  logic signed [15:0] era_ext16, yoe_full;
  logic [8:0]         yoe_q;
  logic [14:0]        p41;
  logic [17:0]        doe_q, doe_d;
  logic [16:0]        tod_q, tod_d;
  logic signed [23:0] era_ext24, days_q, days_d;
  logic signed [38:0] days_ext, secs_q, secs_d;
  logic [EpochW-1:0]  epoch_q;
  logic               res_ok_q;

  always_comb begin
    y_adj    = $signed({1'b0, year_q}) - ((month_q <= 7'd2) ? 15'sd1 : 15'sd0);
    era_prod = {13'b0, y_adj[13:0]} * {14'b0, Recip400};
    era_d    = y_adj[14] ? -6'sd1 : $signed(era_prod[Recip400Sh +: 6]);
    doy_d    = month_offset(month_q) + {2'b00, day_q} - 9'd1;

    era_ext16 = {{10{era_q[5]}}, era_q};
    yoe_full  = {y_q[14], y_q} - era_ext16 * YearsPerEra;

    p41   = {6'b0, yoe_q} * Recip100;
    doe_d = {9'b0, yoe_q} * DaysPerYear + {11'b0, yoe_q[8:2]}
          - {15'b0, p41[14:12]} + {9'b0, doy_q};
    tod_d = {10'b0, hour_q} * SecsPerHour + {10'b0, minute_q} * SecsPerMin
          + {10'b0, second_q};

    era_ext24 = {{18{era_q[5]}}, era_q};
    days_d    = era_ext24 * DaysPerEra + $signed({6'b0, doe_q}) - EpochDayOfs;

    days_ext = {{15{days_q[23]}}, days_q};
    secs_d   = days_ext * SecsPerDay + $signed({22'b0, tod_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_en[StgEra]) begin
      y_q   <= y_adj;
      era_q <= era_d;
      doy_q <= doy_d;
    end
    if (cmd_i.stage_en[StgYoe]) begin
      yoe_q <= yoe_full[8:0];
    end
    if (cmd_i.stage_en[StgDoe]) begin
      doe_q <= doe_d;
      tod_q <= tod_d;
    end
    if (cmd_i.stage_en[StgDays]) begin
      days_q <= days_d;
    end
    if (cmd_i.stage_en[StgSecs]) begin
      secs_q <= secs_d;
    end
    if (cmd_i.load_out) begin
      epoch_q  <= ok_q ? secs_q : '0;
      res_ok_q <= ok_q;
    end
  end

  assign valid_res_o = res_ok_q;
  assign epoch_o     = epoch_q;

endmodule

@@ hdl/its2e_ctrl.sv @@
// Controller: input and output handshakes and sequencing of the epoch stages.
module its2e_ctrl import its2e_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  input  logic s_tlast_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERA,
    ST_YOE,
    ST_DOE,
    ST_DAYS,
    ST_SECS,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    out_free     = !out_valid_q || m_tready_i;
    s_tready_o   = (state_q == ST_IDLE);
    cmd_o        = '0;
    cmd_o.take   = s_tvalid_i && s_tready_o;
    cmd_o.finish = cmd_o.take && s_tlast_i;
    state_d      = state_q;
    out_valid_d  = out_valid_q && !m_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.finish) begin
          state_d = ST_ERA;
        end
      end
      ST_ERA: begin
        cmd_o.stage_en[StgEra] = 1'b1;
        state_d = ST_YOE;
      end
      ST_YOE: begin
        cmd_o.stage_en[StgYoe] = 1'b1;
        state_d = ST_DOE;
      end
      ST_DOE: begin
        cmd_o.stage_en[StgDoe] = 1'b1;
        state_d = ST_DAYS;
      end
      ST_DAYS: begin
        cmd_o.stage_en[StgDays] = 1'b1;
        state_d = ST_SECS;
      end
      ST_SECS: begin
        cmd_o.stage_en[StgSecs] = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

@@ hdl/iso8601_timestamp_to_epoch_top.sv @@
// Top level of the ISO 8601 UTC timestamp to Unix epoch converter.
//
//   Channel   Direction  Word contents
//   s_axis    in         tdata[7:0] ch, tlast last_char
//   m_axis    out        tdata[38:0] epoch_seconds, tuser valid_res
//
// Character words are taken only while the controller is idle. A word with
// tlast set starts the era, year-of-era, day-of-era, days and seconds
// stages, one multiply-add per stage, and then loads the output register
// once m_axis is free; no character is taken until then. While the result
// waits on m_axis the next timestamp's characters are taken. Reset clears
// the position, the error flag and the output valid flag.
module iso8601_timestamp_to_epoch_top import its2e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] ch
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic                m_axis_tuser    // [0] valid_res
);

  cmd_t              cmd;
  logic [EpochW-1:0] epoch;

  its2e_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  its2e_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .ch_i        (s_axis_tdata),
    .valid_res_o (m_axis_tuser),
    .epoch_o     (epoch)
  );

  assign m_axis_tdata = {1'b0, epoch};

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the ISO 8601 timestamp to epoch converter.
module testbench;
  import its2e_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             lst;
  } char_word_t;

  typedef struct {
    logic              ok;
    logic [EpochW-1:0] secs;
  } epoch_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CharW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  char_word_t       char_q[$];
  epoch_result_t    epoch_q[$];
  logic [CharW-1:0] text_q[$];

  logic              in_fire = 1'b0;
  int unsigned       cyc = 0;
  int unsigned       errors = 0;
  int unsigned       results_seen = 0;
  int unsigned       hold_left = 0;
  logic              hold_done = 1'b0;
  logic              quiet;

  // Parser state mirrored from the block.
  logic [PosW-1:0]   pos_q = '0;
  logic              fmt_err = 1'b0;
  logic [YearW-1:0]  year_q = '0;
  logic [FieldW-1:0] month_q = '0;
  logic [FieldW-1:0] day_q = '0;
  logic [FieldW-1:0] hour_q = '0;
  logic [FieldW-1:0] min_q = '0;
  logic [FieldW-1:0] sec_q = '0;

  assign quiet = (cyc >= 2000) && (cyc < 3000);

  iso8601_timestamp_to_epoch_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Days from 1970-01-01 to a proleptic Gregorian date, with March-based years.
  function automatic longint days_since_epoch(longint y, longint m, longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic advance_parser(input logic [CharW-1:0] c, input logic lst);
    logic              is_digit;
    logic [3:0]        dig;
    logic [CharW-1:0]  sep;
    logic              has_sep;
    logic              ok;
    longint            epoch;
    epoch_result_t     res;
    is_digit = (c >= ChZero) && (c <= ChNine);
    dig = is_digit ? 4'(c - ChZero) : 4'd0;
    has_sep = 1'b1;
    case (pos_q)
      5'd4, 5'd7:   sep = ChDash;
      5'd10:        sep = ChT;
      5'd13, 5'd16: sep = ChColon;
      5'd19:        sep = ChZ;
      default: begin
        sep = '0;
        has_sep = 1'b0;
      end
    endcase
    if (pos_q < TsLen) begin
      if (has_sep) begin
        if (c != sep) fmt_err = 1'b1;
      end else if (!is_digit) begin
        fmt_err = 1'b1;
      end else if (pos_q <= 3) begin
        year_q = (pos_q == 0) ? YearW'(dig) : YearW'(year_q * 10 + dig);
      end else if (pos_q <= 6) begin
        month_q = (pos_q == 5) ? FieldW'(dig) : FieldW'(month_q * 10 + dig);
      end else if (pos_q <= 9) begin
        day_q = (pos_q == 8) ? FieldW'(dig) : FieldW'(day_q * 10 + dig);
      end else if (pos_q <= 12) begin
        hour_q = (pos_q == 11) ? FieldW'(dig) : FieldW'(hour_q * 10 + dig);
      end else if (pos_q <= 15) begin
        min_q = (pos_q == 14) ? FieldW'(dig) : FieldW'(min_q * 10 + dig);
      end else begin
        sec_q = (pos_q == 17) ? FieldW'(dig) : FieldW'(sec_q * 10 + dig);
      end
    end
    if (!lst) begin
      if (pos_q != PosMax) pos_q = pos_q + 1'b1;
    end else begin
      ok = !fmt_err && (pos_q == PosLast) && (month_q >= 1) && (month_q <= 12)
           && (day_q >= 1) && (day_q <= 31) && (hour_q <= 23) && (min_q <= 59)
           && (sec_q <= 59);
      epoch = 0;
      if (ok) begin
        epoch = days_since_epoch(longint'(year_q), longint'(month_q), longint'(day_q))
                * 86400 + longint'(hour_q) * 3600 + longint'(min_q) * 60
                + longint'(sec_q);
      end
      res.ok = ok;
      res.secs = epoch[EpochW-1:0];
      epoch_q.push_back(res);
      pos_q = '0;
      fmt_err = 1'b0;
    end
  endtask

  // Move the text buffer into the pending words, tlast on its final character.
  task automatic send_text();
    char_word_t w;
    for (int i = 0; i < text_q.size(); i++) begin
      w.ch = text_q[i];
      w.lst = (i == text_q.size() - 1);
      char_q.push_back(w);
    end
    text_q.delete();
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic load_stamp(input int y, input int mo, input int d, input int h,
                            input int mi, input int s);
    load_text($sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", y, mo, d, h, mi, s));
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || s_axis_tvalid || epoch_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Input side: accept words and predict.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      advance_parser(s_axis_tdata, s_axis_tlast);
  end

  // Output side: compare each result word with the oldest prediction.
  always @(posedge clk_i) begin
    epoch_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (epoch_q.size() == 0) begin
        $display("%0t: unexpected result valid=%0b epoch=%0d", $time, m_axis_tuser,
                 $signed(m_axis_tdata[EpochW-1:0]));
        errors = errors + 1;
      end else begin
        exp_r = epoch_q.pop_front();
        if (m_axis_tuser !== exp_r.ok) begin
          $display("%0t: valid_res mismatch: expected %0b actual %0b", $time, exp_r.ok,
                   m_axis_tuser);
          errors = errors + 1;
        end
        if (m_axis_tdata[EpochW-1:0] !== exp_r.secs) begin
          $display("%0t: epoch_seconds mismatch: expected %0d actual %0d", $time,
                   $signed(exp_r.secs), $signed(m_axis_tdata[EpochW-1:0]));
          errors = errors + 1;
        end
      end
    end
  end

  // Sender.
  always @(negedge clk_i) begin
    char_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (char_q.size() != 0 && (quiet || $urandom_range(99) >= 27)) begin
        w = char_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w.ch;
        s_axis_tlast <= w.lst;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off once results are flowing.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    load_text("1970-01-01T00:00:00Z"); send_text();
    load_text("0000-01-01T00:00:00Z"); send_text();
    load_text("9999-12-31T23:59:59Z"); send_text();
    load_text("2000-02-29T12:34:56Z"); send_text();
    load_text("2024-13-01T00:00:00Z"); send_text();
    load_text("2024-00-10T00:00:00Z"); send_text();
    load_text("2024-02-32T00:00:00Z"); send_text();
    load_text("2024-02-00T00:00:00Z"); send_text();
    load_text("2024-06-15T24:00:00Z"); send_text();
    load_text("2024-06-15T23:60:00Z"); send_text();
    load_text("2024-06-15T23:59:60Z"); send_text();
    load_text("2024-06-15 12:00:00Z"); send_text();
    load_text("2024-06-15T12:00:00X"); send_text();
    load_text("20a4-06-15T12:00:00Z"); send_text();
    load_text("2024-06-15T12:00:00"); send_text();
    text_q.push_back(8'hFF); send_text();
    load_text("2024-06-15T12:00:00Z");
    repeat (20) text_q.push_back(CharW'($urandom_range(255)));
    send_text();
    load_text("1999-12-31T23:59:59Z"); send_text();
    sent = char_q.size();

    wait_drained();

    while (sent < 1450) begin
      kind = $urandom_range(99);
      if ($urandom_range(9) == 0)
        load_stamp($urandom_range(1) ? 0 : 9999, $urandom_range(1) ? 1 : 12,
                   $urandom_range(1) ? 1 : 31, $urandom_range(1) ? 0 : 23,
                   $urandom_range(1) ? 0 : 59, $urandom_range(1) ? 0 : 59);
      else if ($urandom_range(6) == 0)
        load_stamp($urandom_range(9999), $urandom_range(99), $urandom_range(99),
                   $urandom_range(99), $urandom_range(99), $urandom_range(99));
      else
        load_stamp($urandom_range(9999), $urandom_range(1, 12), $urandom_range(1, 31),
                   $urandom_range(23), $urandom_range(59), $urandom_range(59));
      if (kind >= 65 && kind < 80) begin
        text_q[$urandom_range(19)] = CharW'($urandom_range(255));
      end else if (kind >= 80 && kind < 90) begin
        if ($urandom_range(1)) begin
          n = $urandom_range(1, 19);
          while (text_q.size() > n) void'(text_q.pop_back());
        end else begin
          repeat ($urandom_range(1, 15)) text_q.push_back(CharW'($urandom_range(255)));
        end
      end else if (kind >= 90) begin
        text_q.delete();
        repeat ($urandom_range(1, 40)) text_q.push_back(CharW'($urandom_range(255)));
      end
      sent += text_q.size();
      send_text();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench failed");
    $finish;
  end

endmodule

@@ iso8601_timestamp_to_epoch_top.f @@
hdl/its2e_pkg.sv
hdl/its2e_dp.sv
hdl/its2e_ctrl.sv
hdl/iso8601_timestamp_to_epoch_top.sv
test/testbench.sv
